// ===== rtl/core/mlpi_pkg.sv =====
package mlpi_pkg;

  localparam int ACC_W     = 48;
  localparam int VAL_W     = 16;
  localparam int FRAC_BITS = 12;
  localparam int X_W       = 18;
  localparam int IDX_W     = 9;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 4;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;
  localparam int CLS_W     = 3;
  localparam int PROB_W    = 16;
  localparam int EXP_W     = 32;
  localparam int RESULT_LIMIT = 8;

  localparam int DEF_MAX_INPUTS  = 16;
  localparam int DEF_MAX_HIDDEN  = 16;
  localparam int DEF_MAX_CLASSES = 8;

  localparam logic [OP_W-1:0] OP_W_IH    = 2'd0;
  localparam logic [OP_W-1:0] OP_W_HO    = 2'd1;
  localparam logic [OP_W-1:0] OP_FEATURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic                  first;
    logic [IDX_W-1:0]      idx;
    logic signed [X_W-1:0] x;
  } tok_t;

  function automatic logic [15:0] sig_tab(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0:  v = 16'd32768; 6'd1:  v = 16'd36843; 6'd2:  v = 16'd40793;
      6'd3:  v = 16'd44511; 6'd4:  v = 16'd47911; 6'd5:  v = 16'd50941;
      6'd6:  v = 16'd53581; 6'd7:  v = 16'd55834; 6'd8:  v = 16'd57724;
      6'd9:  v = 16'd59287; 6'd10: v = 16'd60565; 6'd11: v = 16'd61598;
      6'd12: v = 16'd62428; 6'd13: v = 16'd63090; 6'd14: v = 16'd63615;
      6'd15: v = 16'd64030; 6'd16: v = 16'd64357; 6'd17: v = 16'd64614;
      6'd18: v = 16'd64816; 6'd19: v = 16'd64974; 6'd20: v = 16'd65097;
      6'd21: v = 16'd65194; 6'd22: v = 16'd65269; 6'd23: v = 16'd65328;
      6'd24: v = 16'd65374; 6'd25: v = 16'd65410; 6'd26: v = 16'd65438;
      6'd27: v = 16'd65459; 6'd28: v = 16'd65476; 6'd29: v = 16'd65489;
      6'd30: v = 16'd65500; 6'd31: v = 16'd65508;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

  function automatic logic [26:0] exp_int_tab(input logic [3:0] i);
    logic [26:0] v;
    case (i)
      4'd0:  v = 27'd22;       4'd1:  v = 27'd60;       4'd2:  v = 27'd162;
      4'd3:  v = 27'd442;      4'd4:  v = 27'd1200;     4'd5:  v = 27'd3263;
      4'd6:  v = 27'd8869;     4'd7:  v = 27'd24109;    4'd8:  v = 27'd65536;
      4'd9:  v = 27'd178145;   4'd10: v = 27'd484249;   4'd11: v = 27'd1316326;
      4'd12: v = 27'd3578144;  4'd13: v = 27'd9726405;  4'd14: v = 27'd26439109;
      default: v = 27'd71868951;
    endcase
    return v;
  endfunction

  function automatic logic [17:0] exp_frac_tab(input logic [3:0] i);
    logic [17:0] v;
    case (i)
      4'd0: v = 18'd65536;  4'd1: v = 18'd74262;  4'd2: v = 18'd84150;
      4'd3: v = 18'd95354;  4'd4: v = 18'd108051; 4'd5: v = 18'd122437;
      4'd6: v = 18'd138740; 4'd7: v = 18'd157213;
      default: v = 18'd178145;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/mlp_one_hidden_layer_infer_unit.sv =====
// One-hidden-layer perceptron inference unit, sigmoid hidden layer, softmax output.
// Input words are taken on a rising edge with start high and busy low. Operation
// selects a weight write to the input-hidden store, a weight write to the
// hidden-output store, or a feature write; row equal to the unit count is the
// bias row. Weight and plain feature words leave busy low. A feature word with
// last_feature set raises busy and runs the forward pass: the features stream
// through a row of hidden MAC cells (one per hidden unit, each holding its own
// weight column), the sums shift out through a shared sigmoid pipeline into a
// row of class MAC cells, the class sums go through a shared exp pipeline, then
// a 17-step divider forms each probability. The divider sets the tail: it works
// on one probability at a time, and the last one is on the ports in the same
// cycle that busy falls. Results come out as one-cycle out_valid strobes, one
// word per class in class order, out_last on the final one; the receiver cannot
// stall them. Configuration writes via cfg_we take effect at once; the user must
// make them only while idle, and the block itself does not enforce this.
// Synchronous reset returns the counts to 16, 16 and 8 and idles the unit;
// weight and feature stores hold whatever they had until written.
module mlp_one_hidden_layer_infer_unit
  import mlpi_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN  = DEF_MAX_HIDDEN,
  parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_column,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_feature,
  output logic                    out_valid,
  output logic [CLS_W-1:0]        out_class_index,
  output logic [PROB_W-1:0]       out_probability,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  localparam int NC_CELLS = (MAX_CLASSES < RESULT_LIMIT) ? MAX_CLASSES : RESULT_LIMIT;
  localparam int CNT_W    = $clog2(MAX_INPUTS + MAX_HIDDEN + 32);
  localparam int FB_AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HWAIT    = MAX_HIDDEN + 5;
  localparam int CWAIT    = NC_CELLS + 8;
  localparam int EWAIT    = 6;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HID    = 9'b000000010,
    S_HWAIT  = 9'b000000100,
    S_HSHIFT = 9'b000001000,
    S_CWAIT  = 9'b000010000,
    S_CSHIFT = 9'b000100000,
    S_EWAIT  = 9'b001000000,
    S_DSTART = 9'b010000000,
    S_DRUN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLS_W-1:0] k_r, k_nxt;

  logic [CFG_DAT_W-1:0] in_cnt_r, hid_cnt_r, cls_cnt_r;
  logic [CNT_W-1:0]     ni, nh, nc;

  logic                    acc_in;
  logic signed [VAL_W-1:0] fb [MAX_INPUTS];
  logic signed [VAL_W-1:0] fb_rd_r;
  logic                    a_v_r;
  logic [CNT_W-1:0]        a_idx_r;

  tok_t                    htok [MAX_HIDDEN+1];
  logic signed [ACC_W-1:0] hacc [MAX_HIDDEN+1];
  tok_t                    ctok [NC_CELLS+1];
  logic signed [ACC_W-1:0] cacc [NC_CELLS+1];

  logic h_wr, c_wr, h_shift, c_shift;
  logic sg_v, ex_v;

  logic             eo_v;
  logic [CLS_W-1:0] eo_idx;
  logic [EXP_W-1:0] eo_e;
  logic [EXP_W-1:0] exps_r [NC_CELLS];
  logic [EXP_W-1:0] sum_r;
  logic [EXP_W:0]   sum_ext;

  logic              div_go, div_done;
  logic [PROB_W-1:0] div_q;

  logic              out_valid_r, out_last_r;
  logic [CLS_W-1:0]  out_cls_r;
  logic [PROB_W-1:0] out_prob_r;

  assign busy   = (state_r != S_IDLE);
  assign acc_in = start && !busy;

  always_comb begin
    if (in_cnt_r == '0) ni = CNT_W'(1);
    else if (32'(in_cnt_r) > 32'(MAX_INPUTS)) ni = CNT_W'(MAX_INPUTS);
    else ni = CNT_W'(in_cnt_r);
    if (hid_cnt_r == '0) nh = CNT_W'(1);
    else if (32'(hid_cnt_r) > 32'(MAX_HIDDEN)) nh = CNT_W'(MAX_HIDDEN);
    else nh = CNT_W'(hid_cnt_r);
    if (cls_cnt_r == '0) nc = CNT_W'(1);
    else if (32'(cls_cnt_r) > 32'(NC_CELLS)) nc = CNT_W'(NC_CELLS);
    else nc = CNT_W'(cls_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= 5'd16;
      hid_cnt_r <= 5'd16;
      cls_cnt_r <= 5'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_COUNT:  in_cnt_r  <= cfg_data;
        CFG_HIDDEN_COUNT: hid_cnt_r <= cfg_data;
        CFG_CLASS_COUNT:  cls_cnt_r <= {1'b0, cfg_data[3:0]};
        default: ;
      endcase
    end
  end

  // feature buffer and the token source of the hidden row
  always_ff @(posedge clk) begin
    if (acc_in && in_operation == OP_FEATURE && 32'(in_row) < 32'(MAX_INPUTS)) begin
      fb[in_row[FB_AW-1:0]] <= in_value;
    end
    fb_rd_r <= fb[cnt_r[FB_AW-1:0]];
    a_idx_r <= cnt_r;
  end

  assign htok[0].valid = a_v_r;
  assign htok[0].first = (a_idx_r == '0);
  assign htok[0].idx   = IDX_W'(a_idx_r);
  assign htok[0].x     = (a_idx_r == ni) ? 18'sd4096 : X_W'(fb_rd_r);
  assign hacc[MAX_HIDDEN] = '0;
  assign cacc[NC_CELLS]   = '0;

  assign h_wr    = acc_in && (in_operation == OP_W_IH);
  assign c_wr    = acc_in && (in_operation == OP_W_HO);
  assign h_shift = (state_r == S_HSHIFT);
  assign c_shift = (state_r == S_CSHIFT);
  assign sg_v    = (state_r == S_HSHIFT);
  assign ex_v    = (state_r == S_CSHIFT);

  for (genvar j = 0; j < MAX_HIDDEN; j++) begin : g_hid
    mlpi_mac_cell #(.DEPTH(MAX_INPUTS + 1), .CELL_ID(j)) u_cell (
      .clk, .rst_n,
      .wr_en(h_wr), .wr_row(in_row), .wr_col(in_column), .wr_data(in_value),
      .tok_i(htok[j]), .tok_o(htok[j+1]),
      .shift(h_shift), .acc_i(hacc[j+1]), .acc_o(hacc[j])
    );
  end

  mlpi_sigmoid u_sig (
    .clk, .rst_n,
    .in_v(sg_v), .in_bias(cnt_r == nh), .in_idx(IDX_W'(cnt_r)), .in_acc(hacc[0]),
    .tok_o(ctok[0])
  );

  for (genvar k = 0; k < NC_CELLS; k++) begin : g_cls
    mlpi_mac_cell #(.DEPTH(MAX_HIDDEN + 1), .CELL_ID(k)) u_cell (
      .clk, .rst_n,
      .wr_en(c_wr), .wr_row(in_row), .wr_col(in_column), .wr_data(in_value),
      .tok_i(ctok[k]), .tok_o(ctok[k+1]),
      .shift(c_shift), .acc_i(cacc[k+1]), .acc_o(cacc[k])
    );
  end

  mlpi_exp u_exp (
    .clk, .rst_n,
    .in_v(ex_v), .in_idx(CLS_W'(cnt_r)), .in_acc(cacc[0]),
    .out_v(eo_v), .out_idx(eo_idx), .out_e(eo_e)
  );

  assign sum_ext = {1'b0, sum_r} + {1'b0, eo_e};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < NC_CELLS; i++) exps_r[i] <= '0;
    end else if (state_r == S_HID) begin
      sum_r <= '0;
    end else if (eo_v) begin
      exps_r[eo_idx] <= eo_e;
      sum_r <= sum_ext[EXP_W] ? '1 : sum_ext[EXP_W-1:0];
    end
  end

  assign div_go = (state_r == S_DSTART);

  mlpi_div u_div (
    .clk, .rst_n,
    .go(div_go), .num(exps_r[k_r]), .den(sum_r),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (acc_in && in_operation == OP_FEATURE && in_last_feature) state_nxt = S_HID;
      end
      S_HID: begin
        if (cnt_r == ni) begin
          state_nxt = S_HWAIT;
          cnt_nxt   = '0;
        end
      end
      S_HWAIT: begin
        if (cnt_r == CNT_W'(HWAIT)) begin
          state_nxt = S_HSHIFT;
          cnt_nxt   = '0;
        end
      end
      S_HSHIFT: begin
        if (cnt_r == nh) begin
          state_nxt = S_CWAIT;
          cnt_nxt   = '0;
        end
      end
      S_CWAIT: begin
        if (cnt_r == CNT_W'(CWAIT)) begin
          state_nxt = S_CSHIFT;
          cnt_nxt   = '0;
        end
      end
      S_CSHIFT: begin
        if (cnt_r == nc - CNT_W'(1)) begin
          state_nxt = S_EWAIT;
          cnt_nxt   = '0;
        end
      end
      S_EWAIT: begin
        if (cnt_r == CNT_W'(EWAIT)) begin
          state_nxt = S_DSTART;
          k_nxt     = '0;
        end
      end
      S_DSTART: state_nxt = S_DRUN;
      S_DRUN: begin
        if (div_done) begin
          if (CNT_W'(k_r) == nc - CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DSTART;
            k_nxt     = k_r + CLS_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      a_v_r       <= (state_r == S_HID);
      out_valid_r <= (state_r == S_DRUN) && div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DRUN && div_done) begin
      out_cls_r  <= k_r;
      out_prob_r <= div_q;
      out_last_r <= (CNT_W'(k_r) == nc - CNT_W'(1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_index = out_cls_r;
  assign out_probability = out_prob_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/mlpi_mac_cell.sv =====
module mlpi_mac_cell
  import mlpi_pkg::*;
#(
  parameter int DEPTH   = DEF_MAX_INPUTS + 1,
  parameter int CELL_ID = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [ROW_W-1:0]        wr_row,
  input  logic [COL_W-1:0]        wr_col,
  input  logic signed [VAL_W-1:0] wr_data,
  input  tok_t                    tok_i,
  output tok_t                    tok_o,
  input  logic                    shift,
  input  logic signed [ACC_W-1:0] acc_i,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int A_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int P_W = X_W + VAL_W;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_r;
  tok_t                    tok_r;
  logic                    pv_r, pf_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    wr_ok;

  assign wr_ok = wr_en && (wr_col == COL_W'(CELL_ID)) && (32'(wr_row) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_row[A_W-1:0]] <= wr_data;
    end
    rd_r <= mem[tok_i.idx[A_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
      pv_r        <= tok_r.valid;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (shift) begin
      acc_nxt = acc_i;
    end else if (pv_r) begin
      acc_nxt = pf_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    tok_r.first <= tok_i.first;
    tok_r.idx   <= tok_i.idx;
    tok_r.x     <= tok_i.x;
    pf_r        <= tok_r.first;
    prod_r      <= tok_r.x * rd_r;
    acc_r       <= acc_nxt;
  end

  assign tok_o = tok_r;
  assign acc_o = acc_r;

endmodule

// ===== rtl/core/mlpi_sigmoid.sv =====
module mlpi_sigmoid
  import mlpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_v,
  input  logic                    in_bias,
  input  logic [IDX_W-1:0]        in_idx,
  input  logic signed [ACC_W-1:0] in_acc,
  output tok_t                    tok_o
);

  logic                    v1_r, v2_r, v3_r;
  logic                    b1_r, b2_r;
  logic [IDX_W-1:0]        i1_r, i2_r, i3_r;
  logic signed [VAL_W-1:0] pre_r;
  logic                    neg_r;
  logic [15:0]             base_r;
  logic [11:0]             diff_r;
  logic [9:0]              fr_r;
  logic signed [X_W-1:0]   x_r;

  logic signed [ACC_W-1:0] sh;
  logic signed [VAL_W-1:0] pre_nxt;
  logic signed [16:0]      pe;
  logic [16:0]             mag;
  logic [6:0]              si;
  logic [21:0]             ip;
  logic [16:0]             sv, hv;

  always_comb begin
    sh = in_acc >>> FRAC_BITS;
    if (sh > 48'sd32767) begin
      pre_nxt = 16'sh7FFF;
    end else if (sh < -48'sd32768) begin
      pre_nxt = -16'sh8000;
    end else begin
      pre_nxt = VAL_W'(sh);
    end
    pe  = 17'(pre_r);
    mag = pre_r[VAL_W-1] ? 17'(-pe) : 17'(pe);
    si  = mag[16:10];
    ip  = 22'(diff_r) * 22'(fr_r);
    sv  = 17'(base_r) + 17'(ip[21:10]);
    hv  = neg_r ? 17'(65536) - sv : sv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_r   <= in_bias;
    i1_r   <= in_idx;
    pre_r  <= pre_nxt;
    b2_r   <= b1_r;
    i2_r   <= i1_r;
    neg_r  <= pre_r[VAL_W-1];
    base_r <= sig_tab(si[5:0]);
    diff_r <= (si >= 7'd32) ? 12'd0 : 12'(sig_tab(si[5:0] + 6'd1) - sig_tab(si[5:0]));
    fr_r   <= mag[9:0];
    i3_r   <= i2_r;
    x_r    <= b2_r ? 18'sd65536 : X_W'(hv);
  end

  assign tok_o.valid = v3_r;
  assign tok_o.first = (i3_r == '0);
  assign tok_o.idx   = i3_r;
  assign tok_o.x     = x_r;

endmodule

// ===== rtl/core/mlpi_exp.sv =====
module mlpi_exp
  import mlpi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_v,
  input  logic [CLS_W-1:0]        in_idx,
  input  logic signed [ACC_W-1:0] in_acc,
  output logic                    out_v,
  output logic [CLS_W-1:0]        out_idx,
  output logic [EXP_W-1:0]        out_e
);

  logic                    v1_r, v2_r, v3_r, v4_r;
  logic [CLS_W-1:0]        i1_r, i2_r, i3_r, i4_r;
  logic signed [VAL_W-1:0] z_r;
  logic [3:0]              n2_r, n3_r;
  logic [17:0]             base_r;
  logic [14:0]             diff_r;
  logic [8:0]              r_r;
  logic [17:0]             ef_r;
  logic [EXP_W-1:0]        e_r;

  logic signed [ACC_W-1:0] sh;
  logic signed [VAL_W-1:0] z_nxt;
  logic [15:0]             zu;
  logic [23:0]             fp;
  logic [44:0]             pp;

  always_comb begin
    sh = in_acc >>> 16;
    if (sh > 48'sd32767) begin
      z_nxt = 16'sh7FFF;
    end else if (sh < -48'sd32768) begin
      z_nxt = -16'sh8000;
    end else begin
      z_nxt = VAL_W'(sh);
    end
    zu = {~z_r[15], z_r[14:0]};
    fp = 24'(diff_r) * 24'(r_r);
    pp = 45'(exp_int_tab(n3_r)) * 45'(ef_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r   <= in_idx;
    z_r    <= z_nxt;
    i2_r   <= i1_r;
    n2_r   <= zu[15:12];
    base_r <= exp_frac_tab({1'b0, zu[11:9]});
    diff_r <= 15'(exp_frac_tab({1'b0, zu[11:9]} + 4'd1) - exp_frac_tab({1'b0, zu[11:9]}));
    r_r    <= zu[8:0];
    i3_r   <= i2_r;
    n3_r   <= n2_r;
    ef_r   <= base_r + 18'(fp[23:9]);
    i4_r   <= i3_r;
    e_r    <= EXP_W'(pp >> 16);
  end

  assign out_v   = v4_r;
  assign out_idx = i4_r;
  assign out_e   = e_r;

endmodule

// ===== rtl/core/mlpi_div.sv =====
module mlpi_div
  import mlpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [EXP_W-1:0]  num,
  input  logic [EXP_W-1:0]  den,
  output logic              done,
  output logic [PROB_W-1:0] quo
);

  logic              run_r, done_r, zero_r;
  logic [4:0]        cnt_r;
  logic [EXP_W:0]    rem_r;
  logic [EXP_W-1:0]  den_r;
  logic [16:0]       q_r, q_nxt;
  logic [PROB_W-1:0] quo_r;
  logic              ge;
  logic [EXP_W:0]    diffr;

  always_comb begin
    ge    = rem_r >= {1'b0, den_r};
    diffr = ge ? rem_r - {1'b0, den_r} : rem_r;
    q_nxt = {q_r[15:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 5'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      zero_r <= (den == '0);
      q_r    <= '0;
      cnt_r  <= 5'd17;
    end else if (run_r) begin
      rem_r <= {diffr[EXP_W-1:0], 1'b0};
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        quo_r <= zero_r ? '0 : (q_nxt[16] ? 16'hFFFF : q_nxt[15:0]);
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
